>>> design/sha1_pkg.sv
// Shared types and constants of the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1_pkg;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // Initial hash values, H0 in element 0.
  localparam logic [4:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Round boundaries of the four round groups.
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  // Word slots in a block.
  localparam logic [3:0] SLOT_LEN_HI = 4'd14;
  localparam logic [3:0] SLOT_LAST   = 4'd15;

  localparam logic [2:0] BYTES_FULL = 3'd4;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_vars_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_PAD   = 5'b01000,
    S_EMIT  = 5'b10000
  } sha1_state_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

endpackage

>>> design/sha1_if.sv
// Channel interfaces of the SHA-1 digest block: message words in, digests out.
`timescale 1ns / 1ps
interface sha1_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;

  modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                  input ready);
  modport sink   (input valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                  output ready);
endinterface

>>> design/sha1_digest.sv
// Top level of the SHA-1 digest block: word buffering, padding and round sequencer.
`timescale 1ns / 1ps
// Usage:
// Message words arrive on the msg channel as big-endian 32-bit beats, each with
// a count of bytes in use and a last mark. Only the last beat of a message may
// carry fewer than four bytes. After the last beat the block appends the 0x80
// byte, zero fill and the 64-bit bit length, and offers the five digest words
// as one beat on the dig channel. It then starts over with the initial hash.
// Flow: a beat that does not complete a 16-word block is taken into the window.
// A beat that completes a block starts the compression: 80 rounds through the
// single round unit, then an add into the hash words. After the last beat the
// padding words are pushed one at a time, each extra block is compressed the
// same way, and the digest register is loaded last.
// The digest sits in an output register, so the next message is accepted while
// a result waits; only a second result stalls until the first has been taken.
// Reset (rst, synchronous) loads the initial hash, clears the length and the
// block fill count, and drops dig.valid.
module sha1_digest (
  input logic       clk,
  input logic       rst,
  sha1_msg_if.sink  msg,
  sha1_dig_if.source dig
);
  import sha1_pkg::*;

  sha1_state_t      state;
  logic [4:0][31:0] h;
  sha1_vars_t       vars;
  sha1_vars_t       vars_next;
  logic [15:0][31:0] win;
  logic [63:0]      bit_length;
  logic [3:0]       wcount;
  logic [6:0]       rnd;

  // Padding progress of the final block(s).
  logic             padding;
  logic             pad_mark;
  logic             hi_done;
  logic             len_done;

  logic             out_valid;
  logic [4:0][31:0] out_h;

  logic             accept;
  logic [2:0]       nb_eff;
  logic [31:0]      first_word;
  logic [31:0]      pad_word;
  logic             push_en;
  logic [31:0]      push_data;
  logic             block_full;
  logic [31:0]      w_new;

  assign accept = msg.valid && msg.ready;
  assign msg.ready = (state == S_IDLE);

  // A short count counts only on the last word, and counts above four mean four.
  assign nb_eff = (!msg.last_word || msg.valid_bytes > BYTES_FULL) ? BYTES_FULL
                                                                   : msg.valid_bytes;

  // The last word carries the 0x80 byte itself unless it is full.
  always_comb begin
    case (nb_eff)
      3'd4:    first_word = msg.data_word;
      3'd3:    first_word = {msg.data_word[31:8], PAD_BYTE};
      3'd2:    first_word = {msg.data_word[31:16], PAD_BYTE, 8'h00};
      3'd1:    first_word = {msg.data_word[31:24], PAD_BYTE, 16'h0000};
      default: first_word = {PAD_BYTE, 24'h000000};
    endcase
  end

  // Words appended after the last message word: the pending 0x80 word, zero
  // fill up to slot 14, then the length high and low words.
  always_comb begin
    if (pad_mark) begin
      pad_word = {PAD_BYTE, 24'h000000};
    end else if (hi_done) begin
      pad_word = bit_length[31:0];
    end else if (wcount == SLOT_LEN_HI) begin
      pad_word = bit_length[63:32];
    end else begin
      pad_word = '0;
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    case (state)
      S_IDLE: begin
        push_en   = accept;
        push_data = msg.last_word ? first_word : msg.data_word;
      end
      S_PAD: begin
        push_en   = 1'b1;
        push_data = pad_word;
      end
      default: begin
        push_en   = 1'b0;
        push_data = '0;
      end
    endcase
  end

  assign block_full = push_en && (wcount == SLOT_LAST);

  // The window shifts by one word each round; the expanded word enters at the
  // top, so the schedule taps are fixed positions.
  assign w_new = rotl1(win[13] ^ win[8] ^ win[2] ^ win[0]);

  sha1_round u_round (
    .round_idx (rnd),
    .vars_cur  (vars),
    .w_cur     (win[0]),
    .vars_next (vars_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      h          <= H_INIT;
      vars       <= '0;
      bit_length <= '0;
      wcount     <= '0;
      rnd        <= '0;
      padding    <= 1'b0;
      pad_mark   <= 1'b0;
      hi_done    <= 1'b0;
      len_done   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // In the emit state the digest register is reloaded below instead.
      if (dig.valid && dig.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      if (push_en) begin
        win    <= {push_data, win[15:1]};
        wcount <= wcount + 4'd1;
        if (block_full) begin
          // Working variable a starts from H0, e from H4.
          vars <= {h[0], h[1], h[2], h[3], h[4]};
          rnd  <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            bit_length <= bit_length + {58'd0, nb_eff, 3'b000};
            if (msg.last_word) begin
              padding  <= 1'b1;
              pad_mark <= (nb_eff == BYTES_FULL);
            end
            if (block_full) begin
              state <= S_ROUND;
            end else if (msg.last_word) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_mark) begin
            pad_mark <= 1'b0;
          end else if (hi_done) begin
            len_done <= 1'b1;
          end else if (wcount == SLOT_LEN_HI) begin
            hi_done <= 1'b1;
          end
          if (block_full) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          vars <= vars_next;
          win  <= {w_new, win[15:1]};
          rnd  <= rnd + 7'd1;
          if (rnd == ROUND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + vars.a;
          h[1] <= h[1] + vars.b;
          h[2] <= h[2] + vars.c;
          h[3] <= h[3] + vars.d;
          h[4] <= h[4] + vars.e;
          rnd  <= '0;
          if (len_done) begin
            state <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || dig.ready) begin
            out_h      <= h;
            out_valid  <= 1'b1;
            h          <= H_INIT;
            bit_length <= '0;
            padding    <= 1'b0;
            hi_done    <= 1'b0;
            len_done   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign dig.valid     = out_valid;
  assign dig.digest_h0 = out_h[0];
  assign dig.digest_h1 = out_h[1];
  assign dig.digest_h2 = out_h[2];
  assign dig.digest_h3 = out_h[3];
  assign dig.digest_h4 = out_h[4];

endmodule

>>> design/sha1_round.sv
// One SHA-1 round: round function, constant select and the five-term add.
`timescale 1ns / 1ps
module sha1_round (
  input  logic [6:0]           round_idx,
  input  sha1_pkg::sha1_vars_t vars_cur,
  input  logic [31:0]          w_cur,
  output sha1_pkg::sha1_vars_t vars_next
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    if (round_idx < ROUND_G1) begin
      f = (vars_cur.b & vars_cur.c) | (~vars_cur.b & vars_cur.d);
      k = K_0;
    end else if (round_idx < ROUND_G2) begin
      f = vars_cur.b ^ vars_cur.c ^ vars_cur.d;
      k = K_1;
    end else if (round_idx < ROUND_G3) begin
      f = (vars_cur.b & vars_cur.c) | (vars_cur.b & vars_cur.d) |
          (vars_cur.c & vars_cur.d);
      k = K_2;
    end else begin
      f = vars_cur.b ^ vars_cur.c ^ vars_cur.d;
      k = K_3;
    end
  end

  assign tmp = {vars_cur.a[26:0], vars_cur.a[31:27]} + f + vars_cur.e + k + w_cur;

  assign vars_next.a = tmp;
  assign vars_next.b = vars_cur.a;
  assign vars_next.c = {vars_cur.b[1:0], vars_cur.b[31:2]};
  assign vars_next.d = vars_cur.c;
  assign vars_next.e = vars_cur.d;

endmodule

>>> design/sha1_digest_chk.sv
// Port-level assertions for the SHA-1 digest block and their bind.
`timescale 1ns / 1ps
module sha1_digest_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_last_word,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] dig_digest_h0
);

  // A last word always takes the block out of idle, into padding or the rounds, so the next beat cannot follow at once.
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && msg_last_word) |=> !msg_ready)
    else $error("message channel ready right after a last word");

  // A new digest appears only as the block returns to taking message words.
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> msg_ready)
    else $error("digest raised while block busy");

  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_digest_h0)))
    else $error("digest beat dropped or changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !dig_valid)
    else $error("digest valid after reset");

endmodule

bind sha1_digest sha1_digest_chk u_sha1_chk (
  .clk           (clk),
  .rst           (rst),
  .msg_valid     (msg.valid),
  .msg_ready     (msg.ready),
  .msg_last_word (msg.last_word),
  .dig_valid     (dig.valid),
  .dig_ready     (dig.ready),
  .dig_digest_h0 (dig.digest_h0)
);
